@@ rtl/uapq_pkg.sv @@
`default_nettype none

package uapq_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;
    localparam int COUNT_W  = 5;

    localparam logic [1:0] OP_INSERT  = 2'd0;
    localparam logic [1:0] OP_EXTRACT = 2'd1;
    localparam logic [1:0] OP_PEEK    = 2'd2;
    localparam logic [1:0] OP_MODIFY  = 2'd3;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_EMPTY    = 2'd1;
    localparam logic [1:0] STATUS_NOTFOUND = 2'd2;
    localparam logic [1:0] STATUS_FULL     = 2'd3;

    typedef struct packed {
        logic [1:0]               op;
        logic signed [DATA_W-1:0] item_value;
        logic signed [DATA_W-1:0] item_priority;
    } in_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] out_value;
        logic signed [DATA_W-1:0] out_priority;
        logic [1:0]               status;
        logic [COUNT_W-1:0]       count;
    } out_t;

endpackage

`default_nettype wire

@@ rtl/unsorted_array_priority_queue.sv @@
`default_nettype none

// Max-priority queue of up to CAPACITY (value, priority) pairs in an unsorted
// table with one read port and one write port. Insert and any operation on an
// empty queue go straight to the completion step without a scan. Peek, and
// modify that finds no match, scan all N entries held; modify that finds a
// match stops at that entry. Extract scans all entries, then moves the last
// entry into the freed slot through S_LAST_RD and S_LAST_WR. The scan reads
// one table entry per cycle through the single read port and compares it in
// one shared signed comparator. The input is not ready while an operation is
// in progress; a finished result waits in the output register while the next
// item is accepted. Ties on priority go to the lowest slot.
module unsorted_array_priority_queue (
    input  wire             aclk,
    input  wire             aresetn,
    input  wire             s_valid,
    output logic            s_ready,
    input  wire uapq_pkg::in_t s_data,
    output logic            m_valid,
    input  wire             m_ready,
    output uapq_pkg::out_t  m_data
);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_SCAN    = 3'd1;
    localparam logic [2:0] S_LAST_RD = 3'd2;
    localparam logic [2:0] S_LAST_WR = 3'd3;
    localparam logic [2:0] S_DONE    = 3'd4;

    localparam int IW = uapq_pkg::IDX_W;
    localparam int CW = uapq_pkg::CNT_W;
    localparam int DW = uapq_pkg::DATA_W;
    localparam logic [CW-1:0] CAP = CW'(uapq_pkg::CAPACITY);

    // Table storage.
    logic [DW-1:0] val_mem [uapq_pkg::CAPACITY];
    logic [DW-1:0] pri_mem [uapq_pkg::CAPACITY];

    logic [2:0]           state_reg, state_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [CW-1:0]        issue_reg, issue_next;
    logic                 rd_valid_reg, rd_valid_next;
    logic [IW-1:0]        rd_idx_reg, rd_idx_next;
    logic [1:0]           op_reg, op_next;
    logic [DW-1:0]        key_reg, key_next;
    logic [DW-1:0]        newpri_reg, newpri_next;
    logic                 found_reg, found_next;
    logic [IW-1:0]        best_idx_reg, best_idx_next;
    logic [DW-1:0]        best_val_reg, best_val_next;
    logic signed [DW-1:0] best_pri_reg, best_pri_next;
    logic [1:0]           status_reg, status_next;
    logic                 m_valid_reg, m_valid_next;
    uapq_pkg::out_t       m_data_reg, m_data_next;

    logic [DW-1:0]        rd_val_reg;
    logic signed [DW-1:0] rd_pri_reg;

    logic          rd_en;
    logic [IW-1:0] rd_addr;
    logic          val_we, pri_we;
    logic [IW-1:0] wr_addr;
    logic [DW-1:0] wr_val, wr_pri;

    logic          accept;
    logic          take_new;
    logic          key_match;
    logic          scan_end;
    logic [31:0]   count_wide;
    logic [CW-1:0] last_cnt;

    assign accept     = s_valid && s_ready;
    assign s_ready    = (state_reg == S_IDLE);
    assign m_valid    = m_valid_reg;
    assign m_data     = m_data_reg;
    assign count_wide = 32'(count_reg);
    assign last_cnt   = count_reg - CW'(1);

    // Shared comparator: a newly read entry beats the running best only when
    // its priority is strictly greater, so the lowest slot wins a tie.
    assign take_new  = rd_valid_reg && (!found_reg || (rd_pri_reg > best_pri_reg));
    assign key_match = rd_valid_reg && (rd_val_reg == key_reg);
    assign scan_end  = (issue_reg == count_reg) && !rd_valid_reg;

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_val_reg <= val_mem[rd_addr];
            rd_pri_reg <= pri_mem[rd_addr];
        end
        if (val_we) begin
            val_mem[wr_addr] <= wr_val;
        end
        if (pri_we) begin
            pri_mem[wr_addr] <= wr_pri;
        end
    end

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        issue_next    = issue_reg;
        rd_valid_next = 1'b0;
        rd_idx_next   = rd_idx_reg;
        op_next       = op_reg;
        key_next      = key_reg;
        newpri_next   = newpri_reg;
        found_next    = found_reg;
        best_idx_next = best_idx_reg;
        best_val_next = best_val_reg;
        best_pri_next = best_pri_reg;
        status_next   = status_reg;
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;

        rd_en   = 1'b0;
        rd_addr = issue_reg[IW-1:0];
        val_we  = 1'b0;
        pri_we  = 1'b0;
        wr_addr = count_reg[IW-1:0];
        wr_val  = s_data.item_value;
        wr_pri  = s_data.item_priority;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    op_next     = s_data.op;
                    key_next    = s_data.item_value;
                    newpri_next = s_data.item_priority;
                    issue_next  = '0;
                    found_next  = 1'b0;
                    status_next = uapq_pkg::STATUS_OK;
                    state_next  = S_DONE;
                    if (s_data.op == uapq_pkg::OP_INSERT) begin
                        if (count_reg == CAP) begin
                            status_next = uapq_pkg::STATUS_FULL;
                        end else begin
                            val_we     = 1'b1;
                            pri_we     = 1'b1;
                            count_next = count_reg + CW'(1);
                        end
                    end else if (count_reg == '0) begin
                        status_next = uapq_pkg::STATUS_EMPTY;
                    end else begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (issue_reg != count_reg) begin
                    rd_en         = 1'b1;
                    rd_valid_next = 1'b1;
                    rd_idx_next   = issue_reg[IW-1:0];
                    issue_next    = issue_reg + CW'(1);
                end
                if (op_reg == uapq_pkg::OP_MODIFY) begin
                    if (key_match) begin
                        pri_we      = 1'b1;
                        wr_addr     = rd_idx_reg;
                        wr_pri      = newpri_reg;
                        status_next = uapq_pkg::STATUS_OK;
                        state_next  = S_DONE;
                    end else if (scan_end) begin
                        status_next = uapq_pkg::STATUS_NOTFOUND;
                        state_next  = S_DONE;
                    end
                end else begin
                    if (take_new) begin
                        found_next    = 1'b1;
                        best_idx_next = rd_idx_reg;
                        best_val_next = rd_val_reg;
                        best_pri_next = rd_pri_reg;
                    end
                    if (scan_end) begin
                        status_next = uapq_pkg::STATUS_OK;
                        state_next  = (op_reg == uapq_pkg::OP_EXTRACT) ? S_LAST_RD : S_DONE;
                    end
                end
            end
            S_LAST_RD: begin
                rd_en      = 1'b1;
                rd_addr    = last_cnt[IW-1:0];
                state_next = S_LAST_WR;
            end
            S_LAST_WR: begin
                // The last entry fills the extracted slot; when it is the same
                // slot the write is harmless since the count drops past it.
                val_we     = 1'b1;
                pri_we     = 1'b1;
                wr_addr    = best_idx_reg;
                wr_val     = rd_val_reg;
                wr_pri     = rd_pri_reg;
                count_next = last_cnt;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next        = 1'b1;
                    m_data_next.status  = status_reg;
                    m_data_next.count   = count_wide[uapq_pkg::COUNT_W-1:0];
                    m_data_next.out_value    = '0;
                    m_data_next.out_priority = '0;
                    if (status_reg == uapq_pkg::STATUS_OK &&
                        (op_reg inside {uapq_pkg::OP_EXTRACT, uapq_pkg::OP_PEEK})) begin
                        m_data_next.out_value    = best_val_reg;
                        m_data_next.out_priority = best_pri_reg;
                    end
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            issue_reg    <= '0;
            rd_valid_reg <= 1'b0;
            found_reg    <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            issue_reg    <= issue_next;
            rd_valid_reg <= rd_valid_next;
            found_reg    <= found_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rd_idx_reg   <= rd_idx_next;
        op_reg       <= op_next;
        key_reg      <= key_next;
        newpri_reg   <= newpri_next;
        best_idx_reg <= best_idx_next;
        best_val_reg <= best_val_next;
        best_pri_reg <= best_pri_next;
        status_reg   <= status_next;
        m_data_reg   <= m_data_next;
    end

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CAP)
        else $error("entry count exceeds capacity");

    a_scan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCAN) |-> (issue_reg <= count_reg))
        else $error("scan ran past the held entries");

    a_extract_shrinks: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_LAST_WR) |=> (count_reg == $past(count_reg) - CW'(1)))
        else $error("extract did not remove exactly one entry");

    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(state_reg) == S_DONE))
        else $error("result presented outside the completion step");

    a_scan_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_LAST_RD) |-> (found_reg && count_reg != '0))
        else $error("extract move started without a selected entry");

endmodule

`default_nettype wire
